>>> hw/rtl/pdc_pkg.sv
// shared types and constants of the playfair digram cipher
package pdc_pkg;

	// symbol fields are one byte on every port
	localparam int SYM_W = 8;
	// width of the row and column count registers
	localparam int SIDE_REG_W = 4;

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_MSG  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_DECRYPT = 2'd0;
	localparam logic [1:0] CFG_ROWS    = 2'd1;
	localparam logic [1:0] CFG_COLS    = 2'd2;
	localparam logic [1:0] CFG_PAD     = 2'd3;

	// register reset values
	localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 4'd5;
	localparam logic [SYM_W-1:0]      PAD_RESET  = 8'd95;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_ODD  = 2'd2
	} status_t;

	// one job handed to the result stage: one or two results
	typedef struct packed {
		logic             from_mem;
		logic             two;
		logic             last;
		status_t          status;
		logic [SYM_W-1:0] sym_a;
		logic [SYM_W-1:0] sym_b;
	} emit_req_t;

endpackage

>>> hw/rtl/pdc_symmap.sv
// symbol to cell map: valid bits in flops, row and column in a synchronous memory
module pdc_symmap #(
	parameter int MAX_SIDE    = 8,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [SYMBOL_BITS-1:0]       wr_addr,
	input  logic [$clog2(MAX_SIDE)-1:0]  wr_row,
	input  logic [$clog2(MAX_SIDE)-1:0]  wr_col,
	input  logic                         re,
	input  logic [SYMBOL_BITS-1:0]       rd_addr_a,
	input  logic [SYMBOL_BITS-1:0]       rd_addr_b,
	output logic                         rd_hit_a,
	output logic [$clog2(MAX_SIDE)-1:0]  rd_row_a,
	output logic [$clog2(MAX_SIDE)-1:0]  rd_col_a,
	output logic                         rd_hit_b,
	output logic [$clog2(MAX_SIDE)-1:0]  rd_row_b,
	output logic [$clog2(MAX_SIDE)-1:0]  rd_col_b
);
	localparam int CW    = $clog2(MAX_SIDE);
	localparam int DEPTH = 2 ** SYMBOL_BITS;

	logic [DEPTH-1:0] valid_q;
	logic [2*CW-1:0]  mem [DEPTH];
	logic [2*CW-1:0]  rd_a_q;
	logic [2*CW-1:0]  rd_b_q;
	logic             hit_a_q;
	logic             hit_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= {wr_row, wr_col};
		end
		if (re) begin
			rd_a_q  <= mem[rd_addr_a];
			rd_b_q  <= mem[rd_addr_b];
			hit_a_q <= valid_q[rd_addr_a];
			hit_b_q <= valid_q[rd_addr_b];
		end
	end

	assign rd_hit_a = hit_a_q;
	assign rd_row_a = rd_a_q[2*CW-1:CW];
	assign rd_col_a = rd_a_q[CW-1:0];
	assign rd_hit_b = hit_b_q;
	assign rd_row_b = rd_b_q[2*CW-1:CW];
	assign rd_col_b = rd_b_q[CW-1:0];

endmodule

>>> hw/rtl/pdc_cellmem.sv
// cell to symbol memory, one write port and a paired read port
module pdc_cellmem #(
	parameter int MAX_SIDE = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(MAX_SIDE)-1:0] wr_row,
	input  logic [$clog2(MAX_SIDE)-1:0] wr_col,
	input  logic [pdc_pkg::SYM_W-1:0]   wr_data,
	input  logic                        re,
	input  logic [$clog2(MAX_SIDE)-1:0] rd_row_a,
	input  logic [$clog2(MAX_SIDE)-1:0] rd_col_a,
	input  logic [$clog2(MAX_SIDE)-1:0] rd_row_b,
	input  logic [$clog2(MAX_SIDE)-1:0] rd_col_b,
	output logic [pdc_pkg::SYM_W-1:0]   rd_data_a,
	output logic [pdc_pkg::SYM_W-1:0]   rd_data_b
);
	import pdc_pkg::*;

	localparam int CW = $clog2(MAX_SIDE);
	localparam int NC = MAX_SIDE * MAX_SIDE;
	localparam int AW = $clog2(NC);

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_SIDE) + AW'(c);
	endfunction

	logic [SYM_W-1:0] mem [NC];
	logic [SYM_W-1:0] rd_a_q;
	logic [SYM_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_of(wr_row, wr_col)] <= wr_data;
		end
		if (re) begin
			rd_a_q <= mem[addr_of(rd_row_a, rd_col_a)];
			rd_b_q <= mem[addr_of(rd_row_b, rd_col_b)];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

>>> hw/rtl/pdc_pair.sv
// digram substitution rules on cell coordinates
module pdc_pair #(
	parameter int MAX_SIDE = 8
) (
	input  logic                        decrypt,
	input  logic [$clog2(MAX_SIDE):0]   rows,
	input  logic [$clog2(MAX_SIDE):0]   cols,
	input  logic [$clog2(MAX_SIDE)-1:0] row_a,
	input  logic [$clog2(MAX_SIDE)-1:0] col_a,
	input  logic [$clog2(MAX_SIDE)-1:0] row_b,
	input  logic [$clog2(MAX_SIDE)-1:0] col_b,
	output logic [$clog2(MAX_SIDE)-1:0] new_row_a,
	output logic [$clog2(MAX_SIDE)-1:0] new_col_a,
	output logic [$clog2(MAX_SIDE)-1:0] new_row_b,
	output logic [$clog2(MAX_SIDE)-1:0] new_col_b
);
	localparam int CW = $clog2(MAX_SIDE);

	// one step with wrap inside the part of the square in use
	function automatic logic [CW-1:0] wrap_step(
		input logic [CW-1:0] v,
		input logic [CW:0]   lim,
		input logic          back
	);
		logic [CW:0] inc;
		inc = {1'b0, v} + 1'b1;
		if (back) begin
			return (v == '0) ? CW'(lim - 1'b1) : v - 1'b1;
		end
		return (inc >= lim) ? '0 : CW'(inc);
	endfunction

	always_comb begin
		new_row_a = row_a;
		new_col_a = col_a;
		new_row_b = row_b;
		new_col_b = col_b;
		if (row_a == row_b) begin
			new_col_a = wrap_step(col_a, cols, decrypt);
			new_col_b = wrap_step(col_b, cols, decrypt);
		end else if (col_a == col_b) begin
			new_row_a = wrap_step(row_a, rows, decrypt);
			new_row_b = wrap_step(row_b, rows, decrypt);
		end else begin
			new_col_a = col_b;
			new_col_b = col_a;
		end
	end

endmodule

>>> hw/rtl/pdc_emit.sv
// result stage: splits a job into results and drives the output register
module pdc_emit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  pdc_pkg::emit_req_t        req,
	input  logic [pdc_pkg::SYM_W-1:0] mem_sym_a,
	input  logic [pdc_pkg::SYM_W-1:0] mem_sym_b,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pdc_pkg::SYM_W-1:0] m_tdata,  // [7:0] out_symbol
	output logic [1:0]                m_tuser,  // [1:0] status
	output logic                      m_tlast
);
	import pdc_pkg::*;

	emit_req_t        job_s3;
	logic             vld_s3;
	logic             idx_s3;
	logic             out_vld_q;
	logic [SYM_W-1:0] out_sym_q;
	status_t          out_st_q;
	logic             out_last_q;
	logic             out_free;
	logic             fire;
	logic             done;
	logic [SYM_W-1:0] nxt_sym;

	assign out_free  = !out_vld_q || m_tready;
	assign fire      = vld_s3 && out_free;
	assign done      = fire && (!job_s3.two || idx_s3);
	assign req_ready = !vld_s3 || done;

	always_comb begin
		if (job_s3.from_mem) begin
			nxt_sym = idx_s3 ? mem_sym_b : mem_sym_a;
		end else begin
			nxt_sym = idx_s3 ? job_s3.sym_b : job_s3.sym_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			idx_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				vld_s3 <= 1'b1;
				idx_s3 <= 1'b0;
			end else if (done) begin
				vld_s3 <= 1'b0;
			end else if (fire) begin
				idx_s3 <= 1'b1;
			end
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			job_s3 <= req;
		end
		if (fire) begin
			out_sym_q  <= nxt_sym;
			out_st_q   <= job_s3.status;
			out_last_q <= job_s3.last && (!job_s3.two || idx_s3);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hw/rtl/playfair_digram_cipher.sv
// generalised playfair digram cipher: top level with pairing control
//
// Playfair substitution over a square of up to MAX_SIDE by MAX_SIDE cells.
// Software loads each cell (command 0 on s_tuser) with its row, column and
// symbol; message symbols (command 1) are then paired and substituted, one
// result per symbol of each pair on the master side, with tlast on the final
// result caused by an input transfer. When encrypting, the pad symbol goes
// between an equal pair and after an odd final symbol; a symbol not in the
// square gives one status-1 result and is dropped; an odd ciphertext end
// gives status 2. Timing: message symbols are taken one per cycle while the
// pipeline has room. A message symbol is looked up in the symbol map (two
// read ports: the symbol and the pad), turned into at most two jobs, and
// each pair job reads the cell memory (two read ports) before its results go
// out through the output register. The single result port sets the sustained
// rate at one result per cycle while the output is not stalled: a symbol gives
// between zero and four results, about one result per symbol for plain text
// and two per symbol when every pair needs a pad. A cell load is taken only
// once no message symbol sits before its cell read, so a load after a message
// waits. The symbol map is cleared at reset by flip-flop valid bits, so there
// is no clearing pass. After its second symbol is taken into the symbol map read,
// the first result of a pair passes the job stage, the cell memory read and the output register.
module playfair_digram_cipher #(
	parameter int MAX_SIDE    = 8,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,  // [2:0] cell_row, [5:3] cell_col, [13:6] symbol
	input  logic                      s_tuser,  // [0] command
	input  logic                      s_tlast,  // end_of_message
	// result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pdc_pkg::SYM_W-1:0] m_tdata,  // [7:0] out_symbol
	output logic [1:0]                m_tuser,  // [1:0] status
	output logic                      m_tlast,  // last_of_run
	// configuration writes
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [pdc_pkg::SYM_W-1:0] cfg_wdata
);
	import pdc_pkg::*;

	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		JOB_PAIR = 2'd0,
		JOB_MISS = 2'd1,
		JOB_ODD  = 2'd2
	} job_kind_t;

	// one pending job: a pair to substitute or a single flagged symbol
	typedef struct packed {
		job_kind_t        kind;
		logic             last;
		logic [SYM_W-1:0] sym_a;
		logic [SYM_W-1:0] sym_b;
		logic             ok_a;
		logic             ok_b;
		logic [CW-1:0]    row_a;
		logic [CW-1:0]    col_a;
		logic [CW-1:0]    row_b;
		logic [CW-1:0]    col_b;
	} job_t;

	// clamp a side count to one .. MAX_SIDE
	function automatic logic [SW-1:0] side_clamp(input logic [SIDE_REG_W-1:0] v);
		logic [4:0] w;
		w = 5'(v);
		if (v == '0) begin
			w = 5'd1;
		end else if (w > 5'(MAX_SIDE)) begin
			w = 5'(MAX_SIDE);
		end
		return SW'(w);
	endfunction

	// configuration registers
	logic                  decrypt_q;
	logic [SIDE_REG_W-1:0] rows_q;
	logic [SIDE_REG_W-1:0] cols_q;
	logic [SYM_W-1:0]      pad_q;
	logic [SW-1:0]         rows_eff;
	logic [SW-1:0]         cols_eff;

	// input fields
	logic [2:0]       in_row;
	logic [2:0]       in_col;
	logic [SYM_W-1:0] in_sym;
	logic             ld_acc;
	logic             msg_acc;
	logic             ld_ok;
	logic [CW-1:0]    ld_row;
	logic [CW-1:0]    ld_col;

	// lookup stage
	logic             vld_s1;
	logic [SYM_W-1:0] sym_s1;
	logic             eom_s1;
	logic             hit_a;
	logic             hit_b;
	logic [CW-1:0]    sa_row;
	logic [CW-1:0]    sa_col;
	logic [CW-1:0]    pa_row;
	logic [CW-1:0]    pa_col;
	logic             ok_s;
	logic             ok_p;
	logic             ok_h;
	logic             s1_adv;

	// held half of a pair
	logic             held_vld_q;
	logic [SYM_W-1:0] held_sym_q;
	logic [CW-1:0]    held_row_q;
	logic [CW-1:0]    held_col_q;
	logic             h_v;
	logic [SYM_W-1:0] h_sym;
	logic [CW-1:0]    h_row;
	logic [CW-1:0]    h_col;

	// job stage
	job_t             job_m;
	job_t             job_e;
	logic             jm_v;
	logic             je_v;
	logic [1:0]       vld_s2;
	job_t             job0_s2;
	job_t             job1_s2;
	job_t             cur;
	logic             pop;
	logic             s2_drain;
	logic             pair_ok;
	emit_req_t        req;
	logic             req_ready;
	logic [CW-1:0]    nr_a;
	logic [CW-1:0]    nc_a;
	logic [CW-1:0]    nr_b;
	logic [CW-1:0]    nc_b;
	logic [SYM_W-1:0] cm_a;
	logic [SYM_W-1:0] cm_b;

	//------------------------------------------------------------------
	// configuration
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			rows_q    <= SIDE_RESET;
			cols_q    <= SIDE_RESET;
			pad_q     <= PAD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DECRYPT: decrypt_q <= cfg_wdata[0];
				CFG_ROWS:    rows_q    <= cfg_wdata[SIDE_REG_W-1:0];
				CFG_COLS:    cols_q    <= cfg_wdata[SIDE_REG_W-1:0];
				CFG_PAD:     pad_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign rows_eff = side_clamp(rows_q);
	assign cols_eff = side_clamp(cols_q);

	//------------------------------------------------------------------
	// input side: loads write both maps at once, message symbols start
	// the symbol map lookup
	//------------------------------------------------------------------
	assign in_row = s_tdata[2:0];
	assign in_col = s_tdata[5:3];
	assign in_sym = s_tdata[13:6];

	// loads wait until no message symbol sits before its cell read
	assign s_tready = (!vld_s1 || s1_adv) &&
	                  ((s_tuser == CMD_MSG) || (!vld_s1 && (vld_s2 == '0)));
	assign ld_acc   = s_tvalid && s_tready && (s_tuser == CMD_LOAD);
	assign msg_acc  = s_tvalid && s_tready && (s_tuser == CMD_MSG);

	assign ld_ok  = (5'(in_row) < 5'(MAX_SIDE)) && (5'(in_col) < 5'(MAX_SIDE)) &&
	                ((in_sym >> SYMBOL_BITS) == '0);
	assign ld_row = CW'(in_row);
	assign ld_col = CW'(in_col);

	pdc_symmap #(
		.MAX_SIDE   (MAX_SIDE),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_symmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (ld_acc && ld_ok),
		.wr_addr  (in_sym[SYMBOL_BITS-1:0]),
		.wr_row   (ld_row),
		.wr_col   (ld_col),
		.re       (msg_acc),
		.rd_addr_a(in_sym[SYMBOL_BITS-1:0]),
		.rd_addr_b(pad_q[SYMBOL_BITS-1:0]),
		.rd_hit_a (hit_a),
		.rd_row_a (sa_row),
		.rd_col_a (sa_col),
		.rd_hit_b (hit_b),
		.rd_row_b (pa_row),
		.rd_col_b (pa_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (msg_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_acc) begin
			sym_s1 <= in_sym;
			eom_s1 <= s_tlast;
		end
	end

	//------------------------------------------------------------------
	// pairing: decide jobs from the looked-up symbol and the held symbol
	//------------------------------------------------------------------
	assign ok_s = hit_a && ((sym_s1 >> SYMBOL_BITS) == '0) &&
	              ({1'b0, sa_row} < rows_eff) && ({1'b0, sa_col} < cols_eff);
	assign ok_p = hit_b && ((pad_q >> SYMBOL_BITS) == '0) &&
	              ({1'b0, pa_row} < rows_eff) && ({1'b0, pa_col} < cols_eff);
	// the held symbol is always mapped, only the bounds can have moved
	assign ok_h = ({1'b0, held_row_q} < rows_eff) && ({1'b0, held_col_q} < cols_eff);

	always_comb begin
		job_m = '0;
		job_e = '0;
		jm_v  = 1'b0;
		je_v  = 1'b0;
		h_v   = held_vld_q;
		h_sym = held_sym_q;
		h_row = held_row_q;
		h_col = held_col_q;

		if (!ok_s) begin
			// not in square: flagged and dropped, held symbol stays
			jm_v        = 1'b1;
			job_m.kind  = JOB_MISS;
			job_m.sym_a = sym_s1;
		end else if (!held_vld_q) begin
			h_v   = 1'b1;
			h_sym = sym_s1;
			h_row = sa_row;
			h_col = sa_col;
		end else if (!decrypt_q && (held_sym_q == sym_s1)) begin
			// equal pair when encrypting: pad goes in, new symbol is held
			jm_v        = 1'b1;
			job_m.kind  = JOB_PAIR;
			job_m.sym_a = held_sym_q;
			job_m.ok_a  = ok_h;
			job_m.row_a = held_row_q;
			job_m.col_a = held_col_q;
			job_m.sym_b = pad_q;
			job_m.ok_b  = ok_p;
			job_m.row_b = pa_row;
			job_m.col_b = pa_col;
			h_row       = sa_row;
			h_col       = sa_col;
		end else begin
			jm_v        = 1'b1;
			job_m.kind  = JOB_PAIR;
			job_m.sym_a = held_sym_q;
			job_m.ok_a  = ok_h;
			job_m.row_a = held_row_q;
			job_m.col_a = held_col_q;
			job_m.sym_b = sym_s1;
			job_m.ok_b  = ok_s;
			job_m.row_b = sa_row;
			job_m.col_b = sa_col;
			h_v         = 1'b0;
		end

		// odd end of message
		if (eom_s1 && h_v) begin
			je_v        = 1'b1;
			job_e.sym_a = h_sym;
			if (decrypt_q) begin
				job_e.kind = JOB_ODD;
			end else begin
				job_e.kind  = JOB_PAIR;
				job_e.ok_a  = (h_row == held_row_q && h_col == held_col_q && held_vld_q) ?
				              ok_h : ok_s;
				job_e.row_a = h_row;
				job_e.col_a = h_col;
				job_e.sym_b = pad_q;
				job_e.ok_b  = ok_p;
				job_e.row_b = pa_row;
				job_e.col_b = pa_col;
			end
			h_v = 1'b0;
		end

		job_m.last = !je_v;
		job_e.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			held_sym_q <= '0;
		end else if (s1_adv) begin
			held_vld_q <= h_v;
			held_sym_q <= h_sym;
		end
	end

	// a load that remaps the held symbol moves its coordinates too
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			held_row_q <= h_row;
			held_col_q <= h_col;
		end else if (ld_acc && ld_ok && held_vld_q && (held_sym_q == in_sym)) begin
			held_row_q <= ld_row;
			held_col_q <= ld_col;
		end
	end

	//------------------------------------------------------------------
	// job stage: up to two jobs per symbol, one issued per transfer
	//------------------------------------------------------------------
	assign s2_drain = (vld_s2 == '0) || (pop && (vld_s2 != 2'b11));
	assign s1_adv   = vld_s1 && s2_drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= '0;
		end else if (s1_adv) begin
			vld_s2 <= {je_v, jm_v};
		end else if (pop) begin
			if (vld_s2[0]) begin
				vld_s2[0] <= 1'b0;
			end else begin
				vld_s2[1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			job0_s2 <= job_m;
			job1_s2 <= job_e;
		end
	end

	assign cur     = vld_s2[0] ? job0_s2 : job1_s2;
	assign pair_ok = (cur.kind == JOB_PAIR) && cur.ok_a && cur.ok_b;
	assign pop     = (vld_s2 != '0) && req_ready;

	always_comb begin
		req          = '0;
		req.from_mem = pair_ok;
		req.two      = (cur.kind == JOB_PAIR);
		req.last     = cur.last;
		req.sym_a    = cur.sym_a;
		req.sym_b    = cur.sym_b;
		if (pair_ok) begin
			req.status = ST_OK;
		end else if (cur.kind == JOB_ODD) begin
			req.status = ST_ODD;
		end else begin
			req.status = ST_MISS;
		end
	end

	pdc_pair #(
		.MAX_SIDE(MAX_SIDE)
	) u_pair (
		.decrypt  (decrypt_q),
		.rows     (rows_eff),
		.cols     (cols_eff),
		.row_a    (cur.row_a),
		.col_a    (cur.col_a),
		.row_b    (cur.row_b),
		.col_b    (cur.col_b),
		.new_row_a(nr_a),
		.new_col_a(nc_a),
		.new_row_b(nr_b),
		.new_col_b(nc_b)
	);

	pdc_cellmem #(
		.MAX_SIDE(MAX_SIDE)
	) u_cellmem (
		.clk      (clk),
		.we       (ld_acc && ld_ok),
		.wr_row   (ld_row),
		.wr_col   (ld_col),
		.wr_data  (in_sym),
		.re       (pop && pair_ok),
		.rd_row_a (nr_a),
		.rd_col_a (nc_a),
		.rd_row_b (nr_b),
		.rd_col_b (nc_b),
		.rd_data_a(cm_a),
		.rd_data_b(cm_b)
	);

	//------------------------------------------------------------------
	// result stage and output register
	//------------------------------------------------------------------
	pdc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(vld_s2 != '0),
		.req_ready(req_ready),
		.req      (req),
		.mem_sym_a(cm_a),
		.mem_sym_b(cm_b),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// a load never overtakes a message symbol still short of its cell read
	a_load_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		ld_acc |-> (!vld_s1 && (vld_s2 == '0)))
		else $error("cell load transfer while a message symbol is in flight");

	// end of message always resolves the held symbol
	a_eom_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && eom_s1) |=> !held_vld_q)
		else $error("held symbol survives end of message");

	// the held flag only moves when a symbol leaves the lookup stage
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(held_vld_q))
		else $error("held flag changed without a pairing step");
`endif

endmodule

>>> tb/tb.sv
// testbench for the playfair digram cipher: random-stall stream traffic against a local predictor
`timescale 1ns / 1ps

module tb;
	import pdc_pkg::*;

	localparam int SIDE_MAX = 8;
	// cycles allowed after the last result for a load or a held symbol to settle
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 46;

	// one input transfer as the generator sees it
	typedef struct packed {
		logic             cmd;
		logic [2:0]       row;
		logic [2:0]       col;
		logic [SYM_W-1:0] sym;
		logic             eom;
	} cipher_item_t;

	// one expected result transfer
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		status_t          status;
		logic             last;
	} cipher_result_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [SYM_W-1:0] m_tdata;
	logic [1:0]       m_tuser;
	logic             m_tlast;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_idx = '0;
	logic [SYM_W-1:0] cfg_wdata = '0;

	playfair_digram_cipher dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // [2:0] cell_row, [5:3] cell_col, [13:6] symbol
		.s_tuser(s_tuser),   // [0] command
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // [7:0] out_symbol
		.m_tuser(m_tuser),   // [1:0] status
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// stimulus waiting for the driver, and results still owed by the block
	cipher_item_t   pending_items[$];
	cipher_result_t cipher_out_q[$];
	cipher_item_t   cur_item;
	logic           took_item = 1'b0;
	logic           steady = 1'b0;
	int             mismatches = 0;
	int             queued_items = 0;

	// predictor state: register shadows, both square maps and the held symbol
	logic             cfg_decrypt = 1'b0;
	logic [3:0]       cfg_rows = SIDE_RESET;
	logic [3:0]       cfg_cols = SIDE_RESET;
	logic [SYM_W-1:0] cfg_pad = PAD_RESET;
	logic             map_ok[256];
	logic [2:0]       map_row[256];
	logic [2:0]       map_col[256];
	logic [SYM_W-1:0] square_cell[64];
	logic [SYM_W-1:0] held_sym = '0;
	logic             held_ok = 1'b0;

	// results caused by the transfer being predicted
	logic [SYM_W-1:0] run_sym[4];
	status_t          run_st[4];
	int               run_n;

	// generator's own view of the square, kept in queue order
	logic [SYM_W-1:0] gen_grid[64];

	initial begin
		for (int i = 0; i < 256; i++) begin
			map_ok[i] = 1'b0;
			map_row[i] = '0;
			map_col[i] = '0;
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// a side register of zero means one, anything above the square means the full side
	function automatic int side_in_use(input logic [3:0] v);
		if (v == 0)
			return 1;
		if (v > SIDE_MAX)
			return SIDE_MAX;
		return v;
	endfunction

	// a symbol counts only if loaded and sitting inside the rows and columns in use
	function automatic logic find_symbol(input logic [SYM_W-1:0] s, output int r, output int c);
		r = map_row[s];
		c = map_col[s];
		return map_ok[s] && r < side_in_use(cfg_rows) && c < side_in_use(cfg_cols);
	endfunction

	// one step along a row or column, with wrap, direction set by the mode
	function automatic int shift_pos(input int v, input int lim);
		if (cfg_decrypt)
			return (v == 0) ? lim - 1 : v - 1;
		return (v + 1 >= lim) ? 0 : v + 1;
	endfunction

	function automatic void queue_result(input logic [SYM_W-1:0] s, input status_t st);
		run_sym[run_n] = s;
		run_st[run_n] = st;
		run_n++;
	endfunction

	function automatic void substitute_pair(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b);
		int r1, c1, r2, c2, tmp;
		logic ok_a, ok_b;
		ok_a = find_symbol(a, r1, c1);
		ok_b = find_symbol(b, r2, c2);
		// either member outside the square: both pass through flagged
		if (!(ok_a && ok_b)) begin
			queue_result(a, ST_MISS);
			queue_result(b, ST_MISS);
			return;
		end
		if (r1 == r2) begin
			c1 = shift_pos(c1, side_in_use(cfg_cols));
			c2 = shift_pos(c2, side_in_use(cfg_cols));
		end else if (c1 == c2) begin
			r1 = shift_pos(r1, side_in_use(cfg_rows));
			r2 = shift_pos(r2, side_in_use(cfg_rows));
		end else begin
			tmp = c1;
			c1 = c2;
			c2 = tmp;
		end
		queue_result(square_cell[r1 * SIDE_MAX + c1], ST_OK);
		queue_result(square_cell[r2 * SIDE_MAX + c2], ST_OK);
	endfunction

	function automatic void playfair_predict(input cipher_item_t it);
		int r, c;
		cipher_result_t res;
		run_n = 0;
		if (it.cmd == CMD_LOAD) begin
			// the symbol that was in the cell keeps its old mapping
			square_cell[it.row * SIDE_MAX + it.col] = it.sym;
			map_ok[it.sym] = 1'b1;
			map_row[it.sym] = it.row;
			map_col[it.sym] = it.col;
			return;
		end
		if (!find_symbol(it.sym, r, c)) begin
			// dropped, the held symbol stays
			queue_result(it.sym, ST_MISS);
		end else if (!held_ok) begin
			held_sym = it.sym;
			held_ok = 1'b1;
		end else if (!cfg_decrypt && held_sym == it.sym) begin
			// equal pair while encrypting: pad goes between, second symbol waits
			substitute_pair(held_sym, cfg_pad);
			held_sym = it.sym;
		end else begin
			substitute_pair(held_sym, it.sym);
			held_ok = 1'b0;
		end
		// odd end of message
		if (it.eom && held_ok) begin
			if (!cfg_decrypt)
				substitute_pair(held_sym, cfg_pad);
			else
				queue_result(held_sym, ST_ODD);
			held_ok = 1'b0;
		end
		for (int i = 0; i < run_n; i++) begin
			res.sym = run_sym[i];
			res.status = run_st[i];
			res.last = (i == run_n - 1);
			cipher_out_q.insert(cipher_out_q.size(), res);
		end
	endfunction

	// ---------------------------------------------------------------- driver and monitor

	// drive at the falling edge; an offered transfer is held until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || took_item) begin
				if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_item.sym, cur_item.col, cur_item.row};
					s_tuser <= cur_item.cmd;
					s_tlast <= cur_item.eom;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 34);
		end
	end

	task automatic flag_mismatch(input string what, input cipher_result_t got,
			input cipher_result_t want);
		$display("%0t mismatch (%s): got sym %0d status %0d last %0b, want sym %0d status %0d last %0b",
			$realtime, what, got.sym, got.status, got.last, want.sym, want.status, want.last);
		mismatches++;
	endtask

	// sample both handshakes at the rising edge; predict before checking
	always @(posedge clk) begin
		cipher_result_t got, want;
		took_item = arst_n && s_tvalid && s_tready;
		if (took_item)
			playfair_predict(cur_item);
		if (arst_n && m_tvalid && m_tready) begin
			got.sym = m_tdata;
			got.status = status_t'(m_tuser);
			got.last = m_tlast;
			if (cipher_out_q.size() == 0) begin
				want = '0;
				flag_mismatch("no result outstanding", got, want);
			end else begin
				want = cipher_out_q.pop_front();
				if (got.sym !== want.sym)
					flag_mismatch("out_symbol", got, want);
				else if (m_tuser !== want.status)
					flag_mismatch("status", got, want);
				else if (m_tlast !== want.last)
					flag_mismatch("last_of_run", got, want);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [SYM_W-1:0] at(input int r, input int c);
		return gen_grid[r * SIDE_MAX + c];
	endfunction

	function automatic void push_load(input int r, input int c, input logic [SYM_W-1:0] s);
		cipher_item_t it;
		it.cmd = CMD_LOAD;
		it.row = 3'(r);
		it.col = 3'(c);
		it.sym = s;
		it.eom = 1'($urandom_range(0, 1));
		gen_grid[r * SIDE_MAX + c] = s;
		pending_items.insert(pending_items.size(), it);
		queued_items++;
	endfunction

	// row and column fields are ignored on a message transfer, so fill them at random
	function automatic void push_msg(input logic [SYM_W-1:0] s, input logic eom);
		cipher_item_t it;
		it.cmd = CMD_MSG;
		it.row = 3'($urandom_range(0, 7));
		it.col = 3'($urandom_range(0, 7));
		it.sym = s;
		it.eom = eom;
		pending_items.insert(pending_items.size(), it);
		queued_items++;
	endfunction

	function automatic logic [SYM_W-1:0] pick_in_square();
		return at($urandom_range(0, side_in_use(cfg_rows) - 1),
			$urandom_range(0, side_in_use(cfg_cols) - 1));
	endfunction

	// mostly symbols from the square in use, with repeats, pads and noise mixed in
	function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] prev);
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return SYM_W'($urandom_range(0, 255));
		if (p < 25)
			return prev;
		if (p < 30)
			return cfg_pad;
		return pick_in_square();
	endfunction

	// four back-to-back register writes, block idle
	task automatic set_config(input logic dec, input logic [3:0] rows, input logic [3:0] cols,
			input logic [SYM_W-1:0] pad);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_DECRYPT;
		cfg_wdata <= {{(SYM_W-1){1'b0}}, dec};
		@(negedge clk);
		cfg_idx <= CFG_ROWS;
		cfg_wdata <= {{(SYM_W-4){1'b0}}, rows};
		@(negedge clk);
		cfg_idx <= CFG_COLS;
		cfg_wdata <= {{(SYM_W-4){1'b0}}, cols};
		@(negedge clk);
		cfg_idx <= CFG_PAD;
		cfg_wdata <= pad;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_decrypt = dec;
		cfg_rows = rows;
		cfg_cols = cols;
		cfg_pad = pad;
		@(posedge clk);
	endtask

	// everything taken and answered, then room for a load or held symbol to settle
	task automatic wait_for_drain();
		@(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || cipher_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int rows_tab[RANDOM_PHASES] = '{8, 1, 3, 15, 0, 5, 8, 2};
		int cols_tab[RANDOM_PHASES] = '{8, 1, 7, 8, 8, 5, 2, 4};
		logic [SYM_W-1:0] pad, prev;
		int len, target;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// fill the whole square so no cell in use is ever read unwritten;
		// distinct symbols, the reset pad sits at row 4 column 4
		for (int i = 0; i < SIDE_MAX * SIDE_MAX; i++)
			push_load(i / SIDE_MAX, i % SIDE_MAX, SYM_W'((i * 4 + 207) & 8'hff));

		// reset settings: encrypt, five by five, pad inside the square
		push_msg(at(0, 0), 1'b0);	// same row, wraps at the right
		push_msg(at(0, 4), 1'b0);
		push_msg(at(1, 4), 1'b0);	// symbol 255, same row
		push_msg(at(1, 0), 1'b0);
		push_msg(at(1, 2), 1'b0);	// same column
		push_msg(at(3, 2), 1'b0);
		push_msg(at(4, 1), 1'b0);	// same column, wraps at the bottom
		push_msg(at(0, 1), 1'b0);
		push_msg(at(1, 1), 1'b0);	// rectangle
		push_msg(at(3, 3), 1'b0);
		push_msg(at(2, 2), 1'b0);	// equal pair then odd end: four results
		push_msg(at(2, 2), 1'b1);
		push_msg(8'd0, 1'b1);		// never loaded
		push_msg(at(0, 0), 1'b0);	// held, then a symbol loaded but outside the square, then odd end
		push_msg(at(6, 6), 1'b1);
		push_msg(at(4, 4), 1'b0);	// equal pair of the pad symbol itself
		push_msg(at(4, 4), 1'b1);
		push_msg(at(2, 0), 1'b1);	// lone symbol padded
		wait_for_drain();

		// decrypt, clamped rows, full columns
		set_config(1'b1, 4'd15, 4'd8, PAD_RESET);
		push_msg(at(3, 0), 1'b0);	// same row, wraps at the left
		push_msg(at(3, 7), 1'b0);
		push_msg(at(0, 5), 1'b0);	// same column, wraps at the top
		push_msg(at(7, 5), 1'b0);
		push_msg(at(6, 1), 1'b0);
		push_msg(at(2, 6), 1'b0);
		push_msg(at(4, 4), 1'b0);	// equal pair goes through without a pad
		push_msg(at(4, 4), 1'b0);
		push_msg(at(1, 1), 1'b1);	// odd ciphertext
		push_msg(at(2, 3), 1'b0);	// left held across the mode change
		wait_for_drain();

		// encrypt over a single row, pad never loaded
		set_config(1'b0, 4'd0, 4'd15, 8'd1);
		push_msg(at(0, 3), 1'b1);	// held partner now outside the square
		push_msg(at(0, 1), 1'b1);	// padded pair not substitutable
		wait_for_drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			cfg_rows = 4'(rows_tab[ph]);
			cfg_cols = 4'(cols_tab[ph]);
			if (ph == 2)
				pad = 8'd0;
			else if (ph == 5)
				pad = 8'd255;
			else if ($urandom_range(0, 3) != 0)
				pad = pick_in_square();
			else
				pad = SYM_W'($urandom_range(0, 255));
			set_config(1'(ph % 2), 4'(rows_tab[ph]), 4'(cols_tab[ph]), pad);
			steady = (ph == 3);
			target = queued_items + ITEMS_PER_PHASE;
			prev = pick_in_square();
			while (queued_items < target) begin
				if ($urandom_range(0, 99) < 5) begin
					push_load($urandom_range(0, 7), $urandom_range(0, 7),
						SYM_W'($urandom_range(0, 255)));
				end else begin
					len = $urandom_range(1, 9);
					for (int k = 0; k < len; k++) begin
						prev = pick_symbol(prev);
						push_msg(prev, k == len - 1);
					end
				end
			end
			wait_for_drain();
		end

		if (mismatches == 0)
			$display("PASS playfair_digram_cipher");
		else
			$display("FAIL playfair_digram_cipher");
		$finish;
	end

	// hang guard
	initial begin
		#4000000;
		$display("FAIL playfair_digram_cipher");
		$finish;
	end

endmodule
